// ===== sv/pgc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pointer gesture classifier.
// No dependencies; used by every module of the block.
package pgc_pkg;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] DCLICK_DELAY_RESET = 32'd250;
   localparam logic [7:0]  DRAG_THRESH_RESET = 8'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DCLICK_DELAY = 1'b0,
      REG_DRAG_THRESH  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MOTION  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      G_NONE        = 3'd0,
      G_PRESS       = 3'd1,
      G_DOUBLE      = 3'd2,
      G_CLICK       = 3'd3,
      G_DRAG_MOVE   = 3'd4,
      G_DRAG_END    = 3'd5,
      G_IGNORED_REL = 3'd6
   } gesture_type;

   typedef struct packed {
      op_type             opcode;
      logic [7:0]         button;
      logic [15:0]        modifiers;
      logic [15:0]        target;
      logic [1:0]         ctx;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [31:0]        event_time;
   } item_type;

   typedef struct packed {
      logic [7:0]         button;
      logic [15:0]        modifiers;
      logic [15:0]        target;
      logic [1:0]         ctx;
      logic signed [15:0] last_x;
      logic signed [15:0] last_y;
      logic [31:0]        last_time;
      logic               has_moved;
      logic               clicked_once;
   } track_type;

   typedef struct packed {
      gesture_type        gesture;
      logic [7:0]         button;
      logic [15:0]        modifiers;
      logic [1:0]         ctx;
      logic signed [16:0] delta_x;
      logic signed [16:0] delta_y;
   } result_type;

   localparam track_type TRACK_RESET = '{
      button:       8'd0,
      modifiers:    16'd0,
      target:       16'd0,
      ctx:          2'd0,
      last_x:       16'hFFFF,
      last_y:       16'hFFFF,
      last_time:    32'd0,
      has_moved:    1'b0,
      clicked_once: 1'b0
   };

endpackage

// ===== sv/pgc_in_reg.sv =====
`timescale 1ns / 1ps
// Input register of the gesture classifier: holds one decoded event.
// Depends on pgc_pkg for the event record.
module pgc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pgc_pkg::item_type in_item,
   output logic              in_ready,
   input  logic              take,
   output logic              valid,
   output pgc_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   pgc_pkg::item_type item_ff;

   assign in_ready = !valid_ff || take;
   assign valid    = valid_ff;
   assign item     = item_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== sv/pgc_track.sv =====
`timescale 1ns / 1ps
// Tracking state of the gesture classifier: held press, last position and time.
// Depends on pgc_pkg for the state record and its reset value.
module pgc_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  pgc_pkg::track_type state_in,
   output pgc_pkg::track_type state
);

   pgc_pkg::track_type state_ff;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgc_pkg::TRACK_RESET;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/pgc_classify.sv =====
`timescale 1ns / 1ps
// Combinational gesture decision: result and next tracking state for one event.
// Depends on pgc_pkg for the event, state and result records.
module pgc_classify (
   input  pgc_pkg::item_type   item,
   input  pgc_pkg::track_type  cur,
   input  logic [31:0]         dclick_delay,
   input  logic [7:0]          drag_thresh,
   output pgc_pkg::result_type res,
   output pgc_pkg::track_type  nxt
);

   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic signed [17:0] dx_w;
   logic signed [17:0] dy_w;
   logic signed [17:0] thr_w;
   logic               in_zone;
   logic [31:0]        time_diff;
   logic               gap_small;
   logic               same_press;

   assign dx    = {item.pos_x[15], item.pos_x} - {cur.last_x[15], cur.last_x};
   assign dy    = {item.pos_y[15], item.pos_y} - {cur.last_y[15], cur.last_y};
   assign dx_w  = {dx[16], dx};
   assign dy_w  = {dy[16], dy};
   assign thr_w = {10'd0, drag_thresh};

   assign in_zone = (dx_w > -thr_w) && (dx_w < thr_w) &&
                    (dy_w > -thr_w) && (dy_w < thr_w);

   assign time_diff = (item.event_time < cur.last_time) ?
                      cur.last_time - item.event_time :
                      item.event_time - cur.last_time;
   assign gap_small = time_diff < dclick_delay;

   assign same_press = item.button == cur.button && item.modifiers == cur.modifiers &&
                       item.target == cur.target && item.ctx == cur.ctx;

   always_comb begin
      res = '0;
      res.gesture = pgc_pkg::G_NONE;
      nxt = cur;
      unique case (item.opcode)
         pgc_pkg::OP_PRESS: begin
            res.gesture   = (cur.clicked_once && gap_small && same_press) ?
                            pgc_pkg::G_DOUBLE : pgc_pkg::G_PRESS;
            res.button    = item.button;
            res.modifiers = item.modifiers;
            res.ctx       = item.ctx;
            nxt.button       = item.button;
            nxt.modifiers    = item.modifiers;
            nxt.target       = item.target;
            nxt.ctx          = item.ctx;
            nxt.last_x       = item.pos_x;
            nxt.last_y       = item.pos_y;
            nxt.last_time    = item.event_time;
            nxt.has_moved    = 1'b0;
            nxt.clicked_once = 1'b0;
         end
         pgc_pkg::OP_RELEASE: begin
            if (item.button != cur.button) begin
               res.gesture = pgc_pkg::G_IGNORED_REL;
               res.button  = item.button;
            end else begin
               if (!cur.has_moved) begin
                  res.gesture      = pgc_pkg::G_CLICK;
                  nxt.clicked_once = 1'b1;
               end else begin
                  res.gesture = pgc_pkg::G_DRAG_END;
               end
               res.button    = cur.button;
               res.modifiers = cur.modifiers;
               res.ctx       = cur.ctx;
            end
         end
         pgc_pkg::OP_MOTION: begin
            if (cur.has_moved || !in_zone) begin
               res.gesture   = pgc_pkg::G_DRAG_MOVE;
               res.button    = cur.button;
               res.modifiers = cur.modifiers;
               res.ctx       = cur.ctx;
               res.delta_x   = dx;
               res.delta_y   = dy;
               nxt.last_time = item.event_time;
               nxt.last_x    = item.pos_x;
               nxt.last_y    = item.pos_y;
               nxt.has_moved = 1'b1;
            end
         end
         default: begin
            res.gesture = pgc_pkg::G_NONE;
         end
      endcase
   end

endmodule

// ===== sv/pointer_gesture_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the pointer gesture classifier: ports, settings, result register.
// Depends on pgc_pkg, pgc_in_reg, pgc_track and pgc_classify.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser opcode, tdata event fields
//   rsp     | out       | rsp_tvalid/tready    | tuser gesture, tdata result fields
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One event per cycle sustained while rsp_tready holds; an event passes the input and then the result register.
// The decision is one level of logic between the input and result registers;
// tracking state is written as the event moves into the result register.
// Reset restores the settings to 250 ms and 3, and returns the tracking state to TRACK_RESET.
// A stalled result holds in its register while the input register still fills.
module pointer_gesture_classifier_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // button_number, modifier_mask, target_id, context_kind, pos_x, pos_y,
   // event_time, zero padding
   input  logic [pgc_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_button, out_modifiers, out_context, delta_x, delta_y, zero padding
   output logic [pgc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // gesture
   output logic [2:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pgc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pgc_pkg::CSR_DATA_W-1:0] csr_data
);

   pgc_pkg::item_type   req_item;
   pgc_pkg::item_type   s1_item;
   logic                s1_valid;
   logic                advance;
   pgc_pkg::track_type  state;
   pgc_pkg::track_type  state_next;
   pgc_pkg::result_type result;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   pgc_pkg::result_type rsp_ff;
   logic [31:0]         dclick_delay_ff;
   logic [7:0]          drag_thresh_ff;

   assign req_item.opcode     = pgc_pkg::op_type'(req_tuser);
   assign req_item.button     = req_tdata[7:0];
   assign req_item.modifiers  = req_tdata[23:8];
   assign req_item.target     = req_tdata[39:24];
   assign req_item.ctx        = req_tdata[41:40];
   assign req_item.pos_x      = req_tdata[57:42];
   assign req_item.pos_y      = req_tdata[73:58];
   assign req_item.event_time = req_tdata[105:74];

   assign advance = s1_valid && (!rsp_valid_ff || rsp_tready);

   pgc_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_item  (req_item),
      .in_ready (req_tready),
      .take     (advance),
      .valid    (s1_valid),
      .item     (s1_item)
   );

   pgc_track u_track (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .state_in (state_next),
      .state    (state)
   );

   pgc_classify u_classify (
      .item         (s1_item),
      .cur          (state),
      .dclick_delay (dclick_delay_ff),
      .drag_thresh  (drag_thresh_ff),
      .res          (result),
      .nxt          (state_next)
   );

   // settings
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dclick_delay_ff <= pgc_pkg::DCLICK_DELAY_RESET;
         drag_thresh_ff  <= pgc_pkg::DRAG_THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (pgc_pkg::reg_index_type'(csr_index))
            pgc_pkg::REG_DCLICK_DELAY: dclick_delay_ff <= csr_data;
            pgc_pkg::REG_DRAG_THRESH:  drag_thresh_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.gesture;
   assign rsp_tdata  = {4'd0, rsp_ff.delta_y, rsp_ff.delta_x, rsp_ff.ctx,
                        rsp_ff.modifiers, rsp_ff.button};

   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.gesture == pgc_pkg::G_NONE |-> rsp_tdata == '0)
      else $error("swallowed event carries payload");

   a_delta_only_move : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.gesture != pgc_pkg::G_DRAG_MOVE |->
         rsp_ff.delta_x == '0 && rsp_ff.delta_y == '0)
      else $error("delta reported outside a drag move");

   a_press_clears_motion : assert property (@(posedge clock) disable iff (reset)
      advance && s1_item.opcode == pgc_pkg::OP_PRESS |=>
         !state.has_moved && !state.clicked_once)
      else $error("press did not clear motion and click flags");

   a_move_sets_moved : assert property (@(posedge clock) disable iff (reset)
      advance && result.gesture == pgc_pkg::G_DRAG_MOVE |=>
         state.has_moved && rsp_valid_ff)
      else $error("drag move did not mark motion");

   a_ignored_release : assert property (@(posedge clock) disable iff (reset)
      advance && result.gesture == pgc_pkg::G_IGNORED_REL |=> $stable(state))
      else $error("ignored release changed tracking state");

endmodule
